FILE: sv/ipv4_tcp_udp_checksum_verifier_defines.svh
// Assertion helpers shared by the checksum verifier.
`ifndef IPV4_TCP_UDP_CHECKSUM_VERIFIER_DEFINES_SVH
`define IPV4_TCP_UDP_CHECKSUM_VERIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icv: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icv: next-cycle check failed");

`endif

FILE: sv/icv_pkg.sv
`default_nettype none
package icv_pkg;

    localparam int ETH_HEADER_BYTES = 14;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] KIND_ICMP  = 2'd0;
    localparam logic [1:0] KIND_TCP   = 2'd1;
    localparam logic [1:0] KIND_UDP   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Byte offsets inside the IPv4 header.
    localparam logic [15:0] IP_OFF_VER_IHL  = 16'd0;
    localparam logic [15:0] IP_OFF_TLEN_HI  = 16'd2;
    localparam logic [15:0] IP_OFF_TLEN_LO  = 16'd3;
    localparam logic [15:0] IP_OFF_PROTO    = 16'd9;
    localparam logic [15:0] IP_OFF_CHK_HI   = 16'd10;
    localparam logic [15:0] IP_OFF_CHK_LO   = 16'd11;
    localparam logic [15:0] IP_OFF_ADDR_BEG = 16'd12;
    localparam logic [15:0] IP_OFF_ADDR_END = 16'd20;
    localparam logic [5:0]  IP_MIN_HDR      = 6'd20;

    // Byte offsets inside the transport header.
    localparam logic [15:0] TCP_OFF_CHK_HI = 16'd16;
    localparam logic [15:0] TCP_OFF_CHK_LO = 16'd17;
    localparam logic [15:0] TCP_MIN_HDR    = 16'd20;
    localparam logic [15:0] UDP_OFF_LEN_HI = 16'd4;
    localparam logic [15:0] UDP_OFF_LEN_LO = 16'd5;
    localparam logic [15:0] UDP_OFF_CHK_HI = 16'd6;
    localparam logic [15:0] UDP_OFF_CHK_LO = 16'd7;
    localparam logic [15:0] UDP_HDR        = 16'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [15:0] ip_computed;
        logic [15:0] ip_received;
        logic        ip_match;
        logic        l4_valid;
        logic [15:0] l4_computed;
        logic [15:0] l4_received;
        logic        l4_match;
        logic        truncated;
    } t_out;

    // Everything the back end needs to finish one frame.
    typedef struct packed {
        logic [15:0] last_pos;
        logic [5:0]  ip_header_bytes;
        logic [7:0]  protocol;
        logic [15:0] ip_sum;
        logic [15:0] l4_sum;
        logic [15:0] ip_check;
        logic [15:0] l4_check;
        logic [15:0] ip_total_length;
        logic [15:0] udp_length;
    } t_summary;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        // With 16-bit operands a single end-around fold cannot carry again.
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage
`default_nettype wire

FILE: sv/icv_front.sv
`default_nettype none
module icv_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire icv_pkg::t_in      i_data,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output icv_pkg::t_summary      o_summary
);

    localparam logic [15:0] ETH_BYTES = 16'(icv_pkg::ETH_HEADER_BYTES);

    logic [15:0] r_pos,      n_pos;
    logic [5:0]  r_hdr,      n_hdr;
    logic [7:0]  r_proto,    n_proto;
    logic [15:0] r_ip_sum,   n_ip_sum;
    logic [15:0] r_l4_sum,   n_l4_sum;
    logic [15:0] r_ip_chk,   n_ip_chk;
    logic [15:0] r_l4_chk,   n_l4_chk;
    logic [15:0] r_tot_len,  n_tot_len;
    logic [15:0] r_udp_len,  n_udp_len;

    logic        accept;
    logic [7:0]  b;
    logic        in_ip;
    logic [15:0] ip_off;
    logic [15:0] l4_off;
    logic [5:0]  hdr_cur;
    logic [15:0] word;
    logic [15:0] udp_ext;
    logic        ip_add;
    logic        l4_add;
    logic        l4_region;

    icv_pkg::t_summary upd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign b       = i_data.data_byte;
    assign o_push  = accept && i_data.last_byte;

    always_comb begin
        in_ip   = r_pos >= ETH_BYTES;
        ip_off  = r_pos - ETH_BYTES;
        hdr_cur = (ip_off == icv_pkg::IP_OFF_VER_IHL) ? {b[3:0], 2'b00} : r_hdr;
        l4_off  = ip_off - {10'd0, hdr_cur};
        // Even offsets carry the high byte of a 16-bit word.
        word    = ip_off[0] ? {8'd0, b} : {b, 8'd0};
        udp_ext = (r_udp_len < icv_pkg::UDP_HDR) ? icv_pkg::UDP_HDR : r_udp_len;
        ip_add  = in_ip && (ip_off < {10'd0, hdr_cur})
                  && (ip_off != icv_pkg::IP_OFF_CHK_HI) && (ip_off != icv_pkg::IP_OFF_CHK_LO);
        l4_region = in_ip && (hdr_cur >= icv_pkg::IP_MIN_HDR) && (ip_off >= {10'd0, hdr_cur});

        upd.last_pos        = r_pos;
        upd.ip_header_bytes = r_hdr;
        upd.protocol        = r_proto;
        upd.ip_sum          = r_ip_sum;
        upd.l4_sum          = r_l4_sum;
        upd.ip_check        = r_ip_chk;
        upd.l4_check        = r_l4_chk;
        upd.ip_total_length = r_tot_len;
        upd.udp_length      = r_udp_len;

        // Pseudo-header addresses go into the transport sum.
        l4_add = in_ip && (ip_off >= icv_pkg::IP_OFF_ADDR_BEG)
                 && (ip_off < icv_pkg::IP_OFF_ADDR_END);

        if (in_ip) begin
            upd.ip_header_bytes = hdr_cur;
            if (ip_add) begin
                upd.ip_sum = icv_pkg::oc_add(r_ip_sum, word);
            end
            if (ip_off == icv_pkg::IP_OFF_TLEN_HI) begin
                upd.ip_total_length = {b, r_tot_len[7:0]};
            end
            if (ip_off == icv_pkg::IP_OFF_TLEN_LO) begin
                upd.ip_total_length = {r_tot_len[15:8], b};
            end
            if (ip_off == icv_pkg::IP_OFF_PROTO) begin
                upd.protocol = b;
            end
            if (ip_off == icv_pkg::IP_OFF_CHK_HI) begin
                upd.ip_check = {b, r_ip_chk[7:0]};
            end
            if (ip_off == icv_pkg::IP_OFF_CHK_LO) begin
                upd.ip_check = {r_ip_chk[15:8], b};
            end
            if (l4_region) begin
                if (r_proto == icv_pkg::PROTO_TCP) begin
                    if (l4_off == icv_pkg::TCP_OFF_CHK_HI) begin
                        upd.l4_check = {b, r_l4_chk[7:0]};
                    end else if (l4_off == icv_pkg::TCP_OFF_CHK_LO) begin
                        upd.l4_check = {r_l4_chk[15:8], b};
                    end else begin
                        l4_add = 1'b1;
                    end
                end else if (r_proto == icv_pkg::PROTO_UDP) begin
                    if (l4_off == icv_pkg::UDP_OFF_LEN_HI) begin
                        upd.udp_length = {b, r_udp_len[7:0]};
                    end
                    if (l4_off == icv_pkg::UDP_OFF_LEN_LO) begin
                        upd.udp_length = {r_udp_len[15:8], b};
                    end
                    if (l4_off == icv_pkg::UDP_OFF_CHK_HI) begin
                        upd.l4_check = {b, r_l4_chk[7:0]};
                    end else if (l4_off == icv_pkg::UDP_OFF_CHK_LO) begin
                        upd.l4_check = {r_l4_chk[15:8], b};
                    end else if (l4_off < udp_ext) begin
                        l4_add = 1'b1;
                    end
                end
            end
        end
        if (l4_add) begin
            upd.l4_sum = icv_pkg::oc_add(r_l4_sum, word);
        end

        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_proto   = r_proto;
        n_ip_sum  = r_ip_sum;
        n_l4_sum  = r_l4_sum;
        n_ip_chk  = r_ip_chk;
        n_l4_chk  = r_l4_chk;
        n_tot_len = r_tot_len;
        n_udp_len = r_udp_len;
        if (accept) begin
            if (i_data.last_byte) begin
                // The frame summary is pushed; start clean for the next frame.
                n_pos     = '0;
                n_hdr     = '0;
                n_proto   = '0;
                n_ip_sum  = '0;
                n_l4_sum  = '0;
                n_ip_chk  = '0;
                n_l4_chk  = '0;
                n_tot_len = '0;
                n_udp_len = '0;
            end else begin
                n_pos     = (r_pos == 16'hFFFF) ? r_pos : r_pos + 16'd1;
                n_hdr     = upd.ip_header_bytes;
                n_proto   = upd.protocol;
                n_ip_sum  = upd.ip_sum;
                n_l4_sum  = upd.l4_sum;
                n_ip_chk  = upd.ip_check;
                n_l4_chk  = upd.l4_check;
                n_tot_len = upd.ip_total_length;
                n_udp_len = upd.udp_length;
            end
        end
    end

    assign o_summary = upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr     <= '0;
            r_proto   <= '0;
            r_ip_sum  <= '0;
            r_l4_sum  <= '0;
            r_ip_chk  <= '0;
            r_l4_chk  <= '0;
            r_tot_len <= '0;
            r_udp_len <= '0;
        end else begin
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_proto   <= n_proto;
            r_ip_sum  <= n_ip_sum;
            r_l4_sum  <= n_l4_sum;
            r_ip_chk  <= n_ip_chk;
            r_l4_chk  <= n_l4_chk;
            r_tot_len <= n_tot_len;
            r_udp_len <= n_udp_len;
        end
    end

endmodule
`default_nettype wire

FILE: sv/icv_queue.sv
`default_nettype none
module icv_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire icv_pkg::t_summary  i_summary,
    input  wire logic               i_pop,
    output icv_pkg::t_summary       o_head,
    output icv_pkg::t_q_status      o_status
);

    localparam logic [icv_pkg::QPTR_W-1:0] LAST_PTR = icv_pkg::QPTR_W'(icv_pkg::QUEUE_DEPTH - 1);
    localparam logic [icv_pkg::QCNT_W-1:0] DEPTH_CNT = icv_pkg::QCNT_W'(icv_pkg::QUEUE_DEPTH);

    icv_pkg::t_summary r_mem [icv_pkg::QUEUE_DEPTH];

    logic [icv_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [icv_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [icv_pkg::QCNT_W-1:0] r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_status = {(r_count == DEPTH_CNT), (r_count == '0)};
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_summary;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: sv/icv_back.sv
`default_nettype none
module icv_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire icv_pkg::t_summary  i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output icv_pkg::t_out           o_data
);

    localparam logic [17:0] ETH_BYTES = 18'(icv_pkg::ETH_HEADER_BYTES);

    logic          r_valid, n_valid;
    icv_pkg::t_out r_data;
    icv_pkg::t_out res;

    logic [1:0]  kind;
    logic [5:0]  hdr_min;
    logic [17:0] end_pos;
    logic [17:0] need_ip;
    logic [17:0] need_l4;
    logic [15:0] udp_ext;
    logic [15:0] pseudo_len;
    logic [17:0] sum3;
    logic [16:0] fold1;
    logic [15:0] l4_sum_fin;
    logic        l4v;

    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    always_comb begin
        case (i_head.protocol)
            icv_pkg::PROTO_ICMP: kind = icv_pkg::KIND_ICMP;
            icv_pkg::PROTO_TCP:  kind = icv_pkg::KIND_TCP;
            icv_pkg::PROTO_UDP:  kind = icv_pkg::KIND_UDP;
            default:             kind = icv_pkg::KIND_OTHER;
        endcase

        hdr_min = (i_head.ip_header_bytes < icv_pkg::IP_MIN_HDR) ?
                  icv_pkg::IP_MIN_HDR : i_head.ip_header_bytes;
        end_pos = {2'b00, i_head.last_pos} + 18'd1;
        need_ip = ETH_BYTES + {12'd0, hdr_min};
        l4v     = (i_head.ip_header_bytes >= icv_pkg::IP_MIN_HDR)
                  && (kind == icv_pkg::KIND_TCP || kind == icv_pkg::KIND_UDP);
        udp_ext = (i_head.udp_length < icv_pkg::UDP_HDR) ? icv_pkg::UDP_HDR : i_head.udp_length;

        if (kind == icv_pkg::KIND_TCP) begin
            pseudo_len = i_head.ip_total_length - {10'd0, i_head.ip_header_bytes};
            need_l4    = ETH_BYTES + {12'd0, i_head.ip_header_bytes}
                         + {2'b00, icv_pkg::TCP_MIN_HDR};
        end else begin
            pseudo_len = i_head.udp_length;
            need_l4    = ETH_BYTES + {12'd0, i_head.ip_header_bytes} + {2'b00, udp_ext};
        end

        // Protocol and length close the pseudo-header; a three-way add folded
        // twice gives the same ones-complement result as two chained adds.
        sum3       = {2'b00, i_head.l4_sum} + {10'd0, i_head.protocol} + {2'b00, pseudo_len};
        fold1      = {1'b0, sum3[15:0]} + {15'd0, sum3[17:16]};
        l4_sum_fin = fold1[15:0] + {15'd0, fold1[16]};

        res.frame_kind  = kind;
        res.ip_computed = ~i_head.ip_sum;
        res.ip_received = i_head.ip_check;
        res.ip_match    = (~i_head.ip_sum == i_head.ip_check);
        res.l4_valid    = l4v;
        res.l4_computed = l4v ? ~l4_sum_fin : 16'd0;
        res.l4_received = l4v ? i_head.l4_check : 16'd0;
        res.l4_match    = l4v && (~l4_sum_fin == i_head.l4_check);
        res.truncated   = (end_pos < need_ip) || (l4v && (end_pos < need_l4));

        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: sv/ipv4_tcp_udp_checksum_verifier.sv
// Throughput: one frame byte per cycle while the summary queue is not full, with no
// gap between frames. With the output free, a frame's summary is queued when its
// last byte is accepted and is then registered into the output register.
// The per-byte 16-bit ones-complement add in the front end sets the byte rate.
// Reset is synchronous and active low; it clears the partial sums, the queue
// and the output valid.
`default_nettype none
`include "ipv4_tcp_udp_checksum_verifier_defines.svh"
module ipv4_tcp_udp_checksum_verifier (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire icv_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output icv_pkg::t_out      o_data
);

    logic                  push;
    logic                  pop;
    icv_pkg::t_summary     summary;
    icv_pkg::t_summary     head;
    icv_pkg::t_q_status    q_status;

    icv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_q_full  (q_status.full),
        .o_push    (push),
        .o_summary (summary)
    );

    icv_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_summary (summary),
        .i_pop     (pop),
        .o_head    (head),
        .o_status  (q_status)
    );

    icv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_status.empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    // A frame summary must never be offered to a full queue.
    `ICV_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, push, !q_status.full)
    // The last byte of a frame leaves a summary in the queue.
    `ICV_ASSERT_NXT(a_last_reaches_queue, i_clk, i_rst_n, i_valid && o_ready && i_data.last_byte, !q_status.empty)
    // An idle output register picks up a waiting summary at once.
    `ICV_ASSERT_NXT(a_back_drains, i_clk, i_rst_n, !q_status.empty && !o_valid, o_valid)

endmodule
`default_nettype wire

FILE: tb/ipv4_tcp_udp_checksum_verifier_test.sv
`timescale 1ns / 100ps
module ipv4_tcp_udp_checksum_verifier_test;

    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_PCT    = 29;
    localparam int ETH_BYTES   = icv_pkg::ETH_HEADER_BYTES;

    // Running state of one frame, kept at the widths the block uses.
    typedef struct packed {
        logic [15:0] pos;
        logic [5:0]  hdr_bytes;
        logic [7:0]  proto;
        logic [15:0] ip_sum;
        logic [15:0] l4_sum;
        logic [15:0] ip_chk;
        logic [15:0] l4_chk;
        logic [15:0] tot_len;
        logic [15:0] udp_len;
    } t_csum_state;

    typedef struct packed {
        icv_pkg::t_in item;
        logic         hold;
    } t_byte_txn;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    icv_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    icv_pkg::t_out o_data;

    t_byte_txn     frame_bytes[$];
    icv_pkg::t_out expected_results[$];
    t_csum_state   model_state;
    int            bytes_accepted;
    int            bytes_planned;
    int            results_seen;
    int            mismatches;
    int            stall;
    logic          no_idle;

    assign no_idle = (bytes_accepted >= 300) && (bytes_accepted < 700);

    ipv4_tcp_udp_checksum_verifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int ones_add(input int acc, input int v);
        int s;
        s = acc + (v & 'hFFFF);
        s = (s & 'hFFFF) + (s >> 16);
        return (s & 'hFFFF) + (s >> 16);
    endfunction

    // Advances the frame state by one byte; returns 1 with the frame result on the last byte.
    function automatic bit csum_step(inout t_csum_state st, input icv_pkg::t_in item,
                                     output icv_pkg::t_out res);
        int p, r, h, q, w, b, need, s, ext, kind;
        bit trunc, l4v;
        b = item.data_byte;
        p = st.pos;
        if (p >= ETH_BYTES) begin
            r = p - ETH_BYTES;
            w = (r & 1) ? b : (b << 8);
            if (r == icv_pkg::IP_OFF_VER_IHL)
                st.hdr_bytes = {item.data_byte[3:0], 2'b00};
            h = st.hdr_bytes;
            if (r < h && r != icv_pkg::IP_OFF_CHK_HI && r != icv_pkg::IP_OFF_CHK_LO)
                st.ip_sum = ones_add(st.ip_sum, w);
            if (r == icv_pkg::IP_OFF_TLEN_HI) st.tot_len[15:8] = item.data_byte;
            if (r == icv_pkg::IP_OFF_TLEN_LO) st.tot_len[7:0] = item.data_byte;
            if (r == icv_pkg::IP_OFF_PROTO) st.proto = item.data_byte;
            if (r == icv_pkg::IP_OFF_CHK_HI) st.ip_chk[15:8] = item.data_byte;
            if (r == icv_pkg::IP_OFF_CHK_LO) st.ip_chk[7:0] = item.data_byte;
            if (r >= icv_pkg::IP_OFF_ADDR_BEG && r < icv_pkg::IP_OFF_ADDR_END)
                st.l4_sum = ones_add(st.l4_sum, w);
            if (h >= icv_pkg::IP_MIN_HDR && r >= h) begin
                q = r - h;
                if (st.proto == icv_pkg::PROTO_TCP) begin
                    if (q == icv_pkg::TCP_OFF_CHK_HI) st.l4_chk[15:8] = item.data_byte;
                    else if (q == icv_pkg::TCP_OFF_CHK_LO) st.l4_chk[7:0] = item.data_byte;
                    else st.l4_sum = ones_add(st.l4_sum, w);
                end else if (st.proto == icv_pkg::PROTO_UDP) begin
                    if (q == icv_pkg::UDP_OFF_LEN_HI) st.udp_len[15:8] = item.data_byte;
                    if (q == icv_pkg::UDP_OFF_LEN_LO) st.udp_len[7:0] = item.data_byte;
                    ext = (st.udp_len < icv_pkg::UDP_HDR) ? icv_pkg::UDP_HDR : st.udp_len;
                    if (q == icv_pkg::UDP_OFF_CHK_HI) st.l4_chk[15:8] = item.data_byte;
                    else if (q == icv_pkg::UDP_OFF_CHK_LO) st.l4_chk[7:0] = item.data_byte;
                    else if (q < ext) st.l4_sum = ones_add(st.l4_sum, w);
                end
            end
        end
        if (st.pos != 16'hFFFF)
            st.pos = st.pos + 16'd1;
        res = '0;
        if (!item.last_byte)
            return 1'b0;

        h = st.hdr_bytes;
        case (st.proto)
            icv_pkg::PROTO_ICMP: kind = icv_pkg::KIND_ICMP;
            icv_pkg::PROTO_TCP:  kind = icv_pkg::KIND_TCP;
            icv_pkg::PROTO_UDP:  kind = icv_pkg::KIND_UDP;
            default:             kind = icv_pkg::KIND_OTHER;
        endcase
        need = ETH_BYTES + ((h < icv_pkg::IP_MIN_HDR) ? icv_pkg::IP_MIN_HDR : h);
        trunc = (p + 1) < need;
        l4v = (h >= icv_pkg::IP_MIN_HDR)
              && (kind == icv_pkg::KIND_TCP || kind == icv_pkg::KIND_UDP);
        if (l4v) begin
            s = ones_add(st.l4_sum, st.proto);
            if (kind == icv_pkg::KIND_TCP) begin
                s = ones_add(s, (st.tot_len - h) & 'hFFFF);
                need = ETH_BYTES + h + icv_pkg::TCP_MIN_HDR;
            end else begin
                s = ones_add(s, st.udp_len);
                ext = (st.udp_len < icv_pkg::UDP_HDR) ? icv_pkg::UDP_HDR : st.udp_len;
                need = ETH_BYTES + h + ext;
            end
            if ((p + 1) < need)
                trunc = 1'b1;
            res.l4_computed = ~s[15:0];
            res.l4_received = st.l4_chk;
            res.l4_match = (res.l4_computed == res.l4_received);
        end
        res.frame_kind  = kind[1:0];
        res.ip_computed = ~st.ip_sum;
        res.ip_received = st.ip_chk;
        res.ip_match    = (res.ip_computed == res.ip_received);
        res.l4_valid    = l4v;
        res.truncated   = trunc;
        st = '0;
        return 1'b1;
    endfunction

    // Builds one frame and queues its bytes. A negative tlen or ulen means a length that
    // agrees with the payload; fill selects random content, all zeros or all ones.
    task automatic add_frame(input int proto, input int ihl, input int pay, input int tlen,
                             input int ulen, input int cut, input bit fix, input int fill,
                             input bit hold);
        logic [7:0]    bytes[$];
        t_csum_state   scratch;
        icv_pkg::t_out res;
        icv_pkg::t_in  it;
        t_byte_txn     txn;
        int            h, size, ver, t, u, i, l4_idx, ip_idx;
        h = ihl * 4;
        size = ETH_BYTES + ((h < icv_pkg::IP_MIN_HDR) ? icv_pkg::IP_MIN_HDR : h) + pay;
        for (i = 0; i < size; i++)
            bytes.push_back(fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom_range(255)));
        if (fill == 0) begin
            ver = ($urandom_range(3) != 0) ? 4 : $urandom_range(15);
            bytes[ETH_BYTES + icv_pkg::IP_OFF_VER_IHL] = {ver[3:0], ihl[3:0]};
            t = (tlen < 0) ? h + pay : tlen;
            bytes[ETH_BYTES + icv_pkg::IP_OFF_TLEN_HI] = t[15:8];
            bytes[ETH_BYTES + icv_pkg::IP_OFF_TLEN_LO] = t[7:0];
            bytes[ETH_BYTES + icv_pkg::IP_OFF_PROTO] = proto[7:0];
            if (h >= icv_pkg::IP_MIN_HDR && proto == icv_pkg::PROTO_UDP &&
                pay > icv_pkg::UDP_OFF_LEN_LO) begin
                u = (ulen < 0) ? pay : ulen;
                bytes[ETH_BYTES + h + icv_pkg::UDP_OFF_LEN_HI] = u[15:8];
                bytes[ETH_BYTES + h + icv_pkg::UDP_OFF_LEN_LO] = u[7:0];
            end
        end
        while (cut > 0 && bytes.size() > cut)
            void'(bytes.pop_back());
        size = bytes.size();
        // Check fields are left out of every sum, so writing the computed values into
        // them yields a frame whose checksums verify.
        if (fix) begin
            scratch = '0;
            for (i = 0; i < size; i++) begin
                it.data_byte = bytes[i];
                it.last_byte = (i == size - 1);
                void'(csum_step(scratch, it, res));
            end
            ip_idx = ETH_BYTES + icv_pkg::IP_OFF_CHK_HI;
            if (ip_idx + 1 < size) begin
                bytes[ip_idx]     = res.ip_computed[15:8];
                bytes[ip_idx + 1] = res.ip_computed[7:0];
            end
            if (res.l4_valid) begin
                l4_idx = ETH_BYTES + h + ((res.frame_kind == icv_pkg::KIND_TCP) ?
                         icv_pkg::TCP_OFF_CHK_HI : icv_pkg::UDP_OFF_CHK_HI);
                if (l4_idx + 1 < size) begin
                    bytes[l4_idx]     = res.l4_computed[15:8];
                    bytes[l4_idx + 1] = res.l4_computed[7:0];
                end
            end
        end
        for (i = 0; i < size; i++) begin
            txn.item.data_byte = bytes[i];
            txn.item.last_byte = (i == size - 1);
            txn.hold = hold && (i == 0);
            frame_bytes.push_back(txn);
        end
        bytes_planned += size;
    endtask

    task automatic add_random_frame();
        int sel, proto, ihl, pay, tlen, ulen, cut;
        sel = $urandom_range(99);
        proto = (sel < 35) ? icv_pkg::PROTO_TCP : (sel < 70) ? icv_pkg::PROTO_UDP :
                (sel < 80) ? icv_pkg::PROTO_ICMP : $urandom_range(255);
        sel = $urandom_range(99);
        ihl = (sel < 80) ? 5 : (sel < 92) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        if (proto == icv_pkg::PROTO_TCP)
            pay = ($urandom_range(3) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 40);
        else if (proto == icv_pkg::PROTO_UDP)
            pay = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 28);
        else
            pay = $urandom_range(0, 24);
        tlen = ($urandom_range(99) < 85) ? -1 : $urandom_range(65535);
        sel = $urandom_range(99);
        ulen = (sel < 80) ? -1 : (sel < 90) ? $urandom_range(0, 12) : $urandom_range(65535);
        cut = ($urandom_range(99) < 15) ? $urandom_range(1, 60) : 0;
        add_frame(proto, ihl, pay, tlen, ulen, cut, $urandom_range(99) < 70, 0,
                  $urandom_range(99) < 4);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("result %0d: %s expected %h got %h", results_seen, what, want, got);
        mismatches++;
    endtask

    // Sender side: one transaction per handshake, the prediction taken at acceptance.
    always @(posedge i_clk) begin : driver
        icv_pkg::t_out res;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                if (csum_step(model_state, frame_bytes[0].item, res))
                    expected_results.push_back(res);
                void'(frame_bytes.pop_front());
                bytes_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (frame_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT) &&
                    !(frame_bytes[0].hold && expected_results.size() != 0)) begin
                    i_valid <= 1'b1;
                    i_data  <= frame_bytes[0].item;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n)
            i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : monitor
        icv_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none outstanding", 0, 1);
            end else begin
                want = expected_results.pop_front();
                if (o_data.frame_kind !== want.frame_kind)
                    report_mismatch("frame_kind", want.frame_kind, o_data.frame_kind);
                if (o_data.ip_computed !== want.ip_computed)
                    report_mismatch("ip_computed", want.ip_computed, o_data.ip_computed);
                if (o_data.ip_received !== want.ip_received)
                    report_mismatch("ip_received", want.ip_received, o_data.ip_received);
                if (o_data.ip_match !== want.ip_match)
                    report_mismatch("ip_match", want.ip_match, o_data.ip_match);
                if (o_data.l4_valid !== want.l4_valid)
                    report_mismatch("l4_valid", want.l4_valid, o_data.l4_valid);
                if (o_data.l4_computed !== want.l4_computed)
                    report_mismatch("l4_computed", want.l4_computed, o_data.l4_computed);
                if (o_data.l4_received !== want.l4_received)
                    report_mismatch("l4_received", want.l4_received, o_data.l4_received);
                if (o_data.l4_match !== want.l4_match)
                    report_mismatch("l4_match", want.l4_match, o_data.l4_match);
                if (o_data.truncated !== want.truncated)
                    report_mismatch("truncated", want.truncated, o_data.truncated);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall <= 0;
        else
            stall <= stall + 1;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        model_state = '0;
        bytes_accepted = 0;
        bytes_planned = 0;
        results_seen = 0;
        mismatches = 0;
        stall = 0;

        // Well-formed frames of each protocol, with verifying checksums.
        add_frame(icv_pkg::PROTO_TCP, 5, 20, -1, -1, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_UDP, 5, 20, -1, -1, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_ICMP, 5, 8, -1, -1, 0, 1, 0, 0);
        add_frame(8'h55, 5, 11, -1, -1, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_TCP, 15, 25, -1, -1, 0, 1, 0, 0);
        // Checksums left as random values.
        add_frame(icv_pkg::PROTO_TCP, 5, 24, -1, -1, 0, 0, 0, 0);
        add_frame(icv_pkg::PROTO_UDP, 5, 13, -1, -1, 0, 0, 0, 0);
        // UDP length below the header size, and beyond the end of the frame.
        add_frame(icv_pkg::PROTO_UDP, 6, 12, -1, 3, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_UDP, 5, 20, -1, 100, 0, 1, 0, 0);
        // Header lengths below five words, including zero.
        add_frame(icv_pkg::PROTO_TCP, 0, 20, -1, -1, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_UDP, 4, 12, -1, -1, 0, 1, 0, 0);
        // Short TCP segment, and a total length smaller than the header.
        add_frame(icv_pkg::PROTO_TCP, 5, 9, -1, -1, 0, 1, 0, 0);
        add_frame(icv_pkg::PROTO_TCP, 5, 20, 4, -1, 0, 1, 0, 1);
        // Frames cut off: one byte, before the protocol byte, inside the IP header.
        add_frame(icv_pkg::PROTO_TCP, 5, 20, -1, -1, 1, 0, 0, 0);
        add_frame(icv_pkg::PROTO_TCP, 5, 20, -1, -1, 20, 0, 0, 0);
        add_frame(icv_pkg::PROTO_UDP, 5, 20, -1, -1, 30, 0, 0, 0);
        // All-zero and all-ones frames.
        add_frame(0, 0, 20, -1, -1, 0, 0, 1, 0);
        add_frame(0, 15, 20, -1, -1, 0, 0, 2, 0);

        while (bytes_planned < 1150)
            add_random_frame();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((frame_bytes.size() != 0 || i_valid || expected_results.size() != 0) &&
               stall < STALL_LIMIT)
            @(posedge i_clk);
        if (stall >= STALL_LIMIT) begin
            $display("ipv4_tcp_udp_checksum_verifier_test NOT OK");
        end else begin
            repeat (8) @(posedge i_clk);
            if (mismatches == 0)
                $display("ipv4_tcp_udp_checksum_verifier_test OK");
            else
                $display("ipv4_tcp_udp_checksum_verifier_test NOT OK");
        end
        $finish;
    end

endmodule
